// ===== rtl/pwm_period_duty_capture_core_defines.svh =====
// ----------------------------------------------------------------------------
// PWM capture assertion macros
// Shared property shorthands for the capture core checkers.
// ----------------------------------------------------------------------------
`ifndef PWM_PERIOD_DUTY_CAPTURE_CORE_DEFINES_SVH
`define PWM_PERIOD_DUTY_CAPTURE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PWMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PWMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pwmc_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM capture package
// Payload types, divider control type and fixed constants of the capture core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pwmc_pkg;

  localparam int RATE_W    = 24;
  localparam int OUT_CNT_W = 32;
  localparam int DUTY_W    = 7;
  localparam int STEP_W    = 5;

  localparam logic [RATE_W-1:0] RATE_RESET   = 24'd250000;
  localparam logic [DUTY_W-1:0] PERCENT      = 7'd100;
  localparam logic [STEP_W-1:0] FREQ_STEPS   = 5'd24;
  localparam logic [STEP_W-1:0] DUTY_STEPS   = 5'd7;

  typedef struct packed {
    logic level;
    logic read_request;
  } pwmc_in_t;

  typedef struct packed {
    logic [RATE_W-1:0]    frequency_hz;
    logic [DUTY_W-1:0]    duty_percent;
    logic [OUT_CNT_W-1:0] period_ticks;
    logic [OUT_CNT_W-1:0] high_ticks;
  } pwmc_out_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } pwmc_div_ctl_t;

endpackage

// ===== rtl/pwmc_capture.sv =====
// ----------------------------------------------------------------------------
// PWM capture phase machine
// Tick counter, edge detect and the four-phase capture of high time and period.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwmc_capture
  import pwmc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  pwmc_in_t               item_i,
  output logic                   rd_hit_o,
  output logic [COUNT_WIDTH-1:0] cap_high_o,
  output logic [COUNT_WIDTH-1:0] cap_period_o
);

  localparam logic [1:0] PH_WAIT_RISE = 2'd0;
  localparam logic [1:0] PH_WAIT_FALL = 2'd1;
  localparam logic [1:0] PH_WAIT_NEXT = 2'd2;
  localparam logic [1:0] PH_HOLD      = 2'd3;

  logic [1:0]             phase_q, phase_d, phase_edge;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  logic [COUNT_WIDTH-1:0] high_q, high_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic                   prev_q;
  logic                   rising, falling, hit;

  assign rising  = item_i.level & ~prev_q;
  assign falling = ~item_i.level & prev_q;
  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    phase_edge = phase_q;
    cnt_d      = cnt_inc;
    high_d     = high_q;
    period_d   = period_q;
    priority if (phase_q == PH_WAIT_RISE && rising) begin
      cnt_d      = '0;
      phase_edge = PH_WAIT_FALL;
    end else if (phase_q == PH_WAIT_FALL && falling) begin
      high_d     = cnt_inc;
      phase_edge = PH_WAIT_NEXT;
    end else if (phase_q == PH_WAIT_NEXT && rising) begin
      period_d   = cnt_inc;
      phase_edge = PH_HOLD;
    end else begin
      phase_edge = phase_q;
    end
    // a read in the held phase rearms the machine
    hit     = item_i.read_request && (phase_edge == PH_HOLD);
    phase_d = hit ? PH_WAIT_RISE : phase_edge;
  end

  assign rd_hit_o     = accept_i & hit;
  assign cap_high_o   = high_q;
  assign cap_period_o = period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_WAIT_RISE;
      cnt_q    <= '0;
      high_q   <= '0;
      period_q <= '0;
      prev_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      high_q   <= high_d;
      period_q <= period_d;
      prev_q   <= item_i.level;
    end
  end

endmodule

// ===== rtl/pwmc_serdiv.sv =====
// ----------------------------------------------------------------------------
// PWM capture serial divider
// Restoring divider: one quotient bit per cycle, dividend bits shifted in MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwmc_serdiv
  import pwmc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pwmc_div_ctl_t          ctl_i,
  input  logic [COUNT_WIDTH-1:0] rem_i,
  input  logic [RATE_W-1:0]      num_i,
  input  logic [COUNT_WIDTH-1:0] den_i,
  output logic [RATE_W-1:0]      quo_o,
  output logic                   done_o
);

  logic [STEP_W-1:0]      cnt_q;
  logic                   done_q;
  logic [COUNT_WIDTH-1:0] rem_q, den_q;
  logic [RATE_W-1:0]      num_q, quo_q;
  logic [COUNT_WIDTH:0]   trial, diff;
  logic                   ge;

  assign trial = {rem_q, num_q[RATE_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      cnt_q  <= ctl_i.steps;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == STEP_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      rem_q <= rem_i;
      num_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
      num_q <= {num_q[RATE_W-2:0], 1'b0};
      quo_q <= {quo_q[RATE_W-2:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== rtl/pwm_period_duty_capture_core.sv =====
// Ticks that do not complete a read leave the core idle; input stays ready while idle.
// A read in the held phase runs from its transfer to the result on the output
// register through load, 24 steps of the serial divider for frequency, 7 for duty,
// and hand-over. Input is not ready until then, also while the output is stalled.
// Reset (rst_ni low, asynchronous) clears the phase machine and counters, empties
// the output register and sets the tick rate register rate_q to 250000.
// ----------------------------------------------------------------------------
// PWM period and duty capture core
// Measures high time and period of a sampled signal and reports them with frequency and duty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pwm_period_duty_capture_core
  import pwmc_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [RATE_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pwmc_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output pwmc_out_t         out_data_o
);

  localparam int DV_W = COUNT_WIDTH + DUTY_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_FREQ = 3'd2;
  localparam logic [2:0] ST_DUTY = 3'd3;
  localparam logic [2:0] ST_HOLD = 3'd4;

  logic [2:0]             state_q, state_d;
  logic [RATE_W-1:0]      rate_q;
  logic                   accept, rd_hit, div_done, div_sel, out_load;
  logic [COUNT_WIDTH-1:0] cap_high, cap_period;
  logic [DV_W-1:0]        h_ext, dv_q;
  logic [RATE_W-1:0]      div_quo, freq_q;
  logic [COUNT_WIDTH-1:0] div_rem;
  logic [RATE_W-1:0]      div_num;
  pwmc_div_ctl_t          div_ctl;
  logic [DUTY_W-1:0]      quo_duty, duty;
  logic                   period_zero;
  logic [OUT_CNT_W-1:0]   period_c, high_c;
  logic                   out_valid_q;
  pwmc_out_t              out_q;

  assign accept      = in_valid_i & in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_valid_i) begin
      rate_q <= cfg_data_i;
    end
  end

  pwmc_capture #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_data_i),
    .rd_hit_o    (rd_hit),
    .cap_high_o  (cap_high),
    .cap_period_o(cap_period)
  );

  // duty dividend: high * 100 = high * 64 + high * 32 + high * 4
  assign h_ext = DV_W'(cap_high);

  assign div_rem = div_sel ? dv_q[DV_W-1:DUTY_W] : '0;
  assign div_num = div_sel ? {dv_q[DUTY_W-1:0], {(RATE_W-DUTY_W){1'b0}}} : rate_q;

  pwmc_serdiv #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_serdiv (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (div_ctl),
    .rem_i (div_rem),
    .num_i (div_num),
    .den_i (cap_period),
    .quo_o (div_quo),
    .done_o(div_done)
  );

  always_comb begin
    state_d       = state_q;
    div_ctl       = '0;
    div_sel       = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (rd_hit) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = FREQ_STEPS;
        state_d       = ST_FREQ;
      end
      ST_FREQ: begin
        if (div_done) begin
          div_ctl.start = 1'b1;
          div_ctl.steps = DUTY_STEPS;
          div_sel       = 1'b1;
          state_d       = ST_DUTY;
        end
      end
      ST_DUTY: begin
        if (div_done) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign period_zero = (cap_period == '0);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      dv_q <= (h_ext << 6) + (h_ext << 5) + (h_ext << 2);
    end
    if (state_q == ST_FREQ && div_done) begin
      freq_q <= period_zero ? '0 : div_quo;
    end
  end

  assign quo_duty = div_quo[DUTY_W-1:0];
  assign duty     = period_zero ? '0 : ((quo_duty > PERCENT) ? PERCENT : quo_duty);

  generate
    if (COUNT_WIDTH > OUT_CNT_W) begin : g_clamp
      assign period_c = (|cap_period[COUNT_WIDTH-1:OUT_CNT_W]) ? '1
                                                                : cap_period[OUT_CNT_W-1:0];
      assign high_c   = (|cap_high[COUNT_WIDTH-1:OUT_CNT_W]) ? '1
                                                              : cap_high[OUT_CNT_W-1:0];
    end else begin : g_extend
      assign period_c = OUT_CNT_W'(cap_period);
      assign high_c   = OUT_CNT_W'(cap_high);
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.frequency_hz <= freq_q;
      out_q.duty_percent <= duty;
      out_q.period_ticks <= period_c;
      out_q.high_ticks   <= high_c;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pwmc_checker.sv =====
// ----------------------------------------------------------------------------
// PWM capture port checker
// Port-level properties of the capture core, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pwm_period_duty_capture_core_defines.svh"

module pwmc_checker
  import pwmc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input pwmc_out_t         out_data_o
);

  logic out_stall, in_xfer, duty_ok, high_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_xfer   = in_valid_i && in_ready_o;
  assign duty_ok   = out_data_o.duty_percent <= PERCENT;
  assign high_ok   = out_data_o.high_ticks <= out_data_o.period_ticks;

  `PWMC_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_data_o), "result not held")
  `PWMC_ASSERT_NOW(a_duty_range, out_valid_o, duty_ok, "duty above 100 percent")
  `PWMC_ASSERT_NOW(a_high_le_period, out_valid_o, high_ok, "high time exceeds period")
  `PWMC_ASSERT_NEXT(a_no_instant_result, in_xfer, !$rose(out_valid_o), "result too early")

endmodule

bind pwm_period_duty_capture_core pwmc_checker u_pwmc_checker (.*);
